/* src/matmul_2x2_instruction_unit_core_defines.svh */
// assertion macros for the 2x2 matrix multiply instruction unit
`ifndef MATMUL_2X2_INSTRUCTION_UNIT_CORE_DEFINES_SVH
`define MATMUL_2X2_INSTRUCTION_UNIT_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MM2_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, checked outside reset
`define MM2_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, also checked through reset
`define MM2_ASSERT_NEXT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

/* src/mm2_pkg.sv */
// types and constants of the 2x2 matrix multiply instruction unit
`default_nettype none
package mm2_pkg;

    localparam logic [1:0] FN_MEM_WR = 2'd0;
    localparam logic [1:0] FN_MEM_RD = 2'd1;
    localparam logic [1:0] FN_REG_WR = 2'd2;
    localparam logic [1:0] FN_EXEC   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_OOB     = 2'd2;

    localparam logic [6:0] OP_MATMUL = 7'h2B;
    localparam logic [2:0] F3_MATMUL = 3'h7;
    localparam logic [6:0] F7_MATMUL = 7'h01;

    typedef struct packed {
        logic [1:0]         func;
        logic [31:0]        mem_address;
        logic signed [31:0] write_data;
        logic [4:0]         reg_index;
        logic [31:0]        instruction;
    } t_req;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic [1:0]         status;
    } t_rsp;

    typedef struct packed {
        logic en;
        logic we;
    } t_mem_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RF,
        S_RD,
        S_MUL,
        S_WR,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

/* src/mm2_byte_ram.sv */
// byte-wide single-port memory with registered read data
`default_nettype none
module mm2_byte_ram #(
    parameter int MEM_BYTES = 65536
) (
    input  wire                         i_clk,
    input  mm2_pkg::t_mem_ctl           i_ctl,
    input  wire [$clog2(MEM_BYTES)-1:0] i_addr,
    input  wire [7:0]                   i_wdata,
    output logic [7:0]                  o_rdata
);
    import mm2_pkg::*;

    logic [7:0] r_mem [MEM_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_ctl.we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                o_rdata <= r_mem[i_addr];
            end
        end
    end

endmodule
`default_nettype wire

/* src/mm2_reg_ram.sv */
// 32 x 32 register file memory, entries read as zero until written
`default_nettype none
module mm2_reg_ram (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  mm2_pkg::t_mem_ctl i_ctl,
    input  wire [4:0]         i_addr,
    input  wire [31:0]        i_wdata,
    output logic [31:0]       o_rdata
);
    import mm2_pkg::*;

    logic [31:0] r_mem [32];
    logic [31:0] r_vld;
    logic [31:0] r_data;
    logic        r_data_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en && i_ctl.we) begin
            r_vld[i_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_ctl.we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_data     <= r_mem[i_addr];
                r_data_vld <= r_vld[i_addr];
            end
        end
    end

    assign o_rdata = r_data_vld ? r_data : '0;

endmodule
`default_nettype wire

/* src/mm2_ctrl.sv */
// sequencer and datapath: decode, memory walks and the shared multiplier
`default_nettype none
module mm2_ctrl #(
    parameter int MEM_BYTES = 65536
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_req_valid,
    output logic                         o_req_ready,
    input  mm2_pkg::t_req                i_req,
    output logic                         o_rsp_valid,
    input  wire                          i_rsp_ready,
    output mm2_pkg::t_rsp                o_rsp,
    output mm2_pkg::t_mem_ctl            o_rf_ctl,
    output logic [4:0]                   o_rf_addr,
    output logic [31:0]                  o_rf_wdata,
    input  wire [31:0]                   i_rf_rdata,
    output mm2_pkg::t_mem_ctl            o_bm_ctl,
    output logic [$clog2(MEM_BYTES)-1:0] o_bm_addr,
    output logic [7:0]                   o_bm_wdata,
    input  wire [7:0]                    i_bm_rdata
);
    import mm2_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [33:0] MemLimit = 34'(MEM_BYTES);

    t_state      r_state, n_state;
    logic [4:0]  r_cnt, n_cnt;
    t_req        r_req;
    logic        r_bad;
    logic        r_illegal;
    logic [31:0] r_pa, r_pb, r_pr;
    logic [31:0] r_ab  [8];
    logic [31:0] r_res [4];
    logic        r_cap_vld;
    logic [4:0]  r_cap_idx;
    logic        r_cap_ok;
    logic [31:0] r_prod;
    logic [2:0]  r_pt;
    logic        r_pv;
    logic        r_rsp_valid;
    t_rsp        r_rsp;

    logic        w_acc, w_exec, w_legal, w_load, w_last;
    logic [31:0] w_base;
    logic [33:0] w_word_addr, w_byte_addr;
    logic        w_ok;

    assign w_acc   = i_req_valid && o_req_ready;
    assign w_exec  = (r_req.func == FN_EXEC);
    assign w_legal = (i_req.instruction[6:0] == OP_MATMUL)
                  && (i_req.instruction[14:12] == F3_MATMUL)
                  && (i_req.instruction[31:25] == F7_MATMUL);
    assign w_load  = (r_state == S_DONE) && !r_cap_vld && (!r_rsp_valid || i_rsp_ready);
    assign w_last  = (r_state == S_RD) ? (r_cnt == (w_exec ? 5'd31 : 5'd3))
                                       : (r_cnt == (w_exec ? 5'd15 : 5'd3));

    // word address: base plus 4 per word, bounds taken without wrap
    assign w_base      = (r_state == S_WR) ? r_pr : ((w_exec && r_cnt[4]) ? r_pb : r_pa);
    assign w_word_addr = {2'b00, w_base} + {30'd0, r_cnt[3:2], 2'b00};
    assign w_byte_addr = w_word_addr + {32'd0, r_cnt[1:0]};
    assign w_ok        = (w_word_addr + 34'd3) < MemLimit;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (i_req.func)
                        FN_MEM_WR: n_state = S_WR;
                        FN_MEM_RD: n_state = S_RD;
                        FN_REG_WR: n_state = S_DONE;
                        FN_EXEC:   n_state = w_legal ? S_RF : S_DONE;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_RF: begin
                if (r_cnt == 5'd3) n_state = S_RD;
            end
            S_RD: begin
                if (w_last) n_state = w_exec ? S_MUL : S_DONE;
            end
            S_MUL: begin
                if (r_cnt == 5'd8) n_state = S_WR;
            end
            S_WR: begin
                if (w_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        n_cnt = (n_state != r_state) ? 5'd0 : r_cnt + 5'd1;
    end

    always_comb begin
        o_req_ready = (r_state == S_IDLE);
        o_rf_ctl    = '0;
        o_rf_addr   = r_req.instruction[11:7];
        o_rf_wdata  = i_req.write_data;
        o_bm_ctl    = '0;
        o_bm_addr   = w_byte_addr[AW-1:0];
        o_bm_wdata  = r_res[r_cnt[3:2]][{r_cnt[1:0], 3'b000} +: 8];
        unique case (r_state)
            S_IDLE: begin
                o_rf_addr   = i_req.reg_index;
                o_rf_ctl.en = w_acc && (i_req.func == FN_REG_WR);
                o_rf_ctl.we = 1'b1;
            end
            S_RF: begin
                o_rf_ctl.en = (r_cnt < 5'd3);
                unique case (r_cnt[1:0])
                    2'd0:    o_rf_addr = r_req.instruction[19:15];
                    2'd1:    o_rf_addr = r_req.instruction[24:20];
                    default: o_rf_addr = r_req.instruction[11:7];
                endcase
            end
            S_RD: begin
                o_bm_ctl.en = w_ok;
            end
            S_WR: begin
                o_bm_ctl.en = w_ok;
                o_bm_ctl.we = 1'b1;
            end
            default: begin
                o_bm_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_cap_vld   <= 1'b0;
            r_pv        <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_cap_vld <= (r_state == S_RD);
            r_pv      <= (r_state == S_MUL) && (r_cnt < 5'd8);
            if (w_load) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_req     <= i_req;
            r_bad     <= 1'b0;
            r_illegal <= (i_req.func == FN_EXEC) && !w_legal;
            r_pa      <= i_req.mem_address;
            r_pr      <= i_req.mem_address;
            r_res[0]  <= i_req.write_data;
        end
        if (r_state == S_RF) begin
            unique case (r_cnt[1:0])
                2'd1:    r_pa <= i_rf_rdata;
                2'd2:    r_pb <= i_rf_rdata;
                2'd3:    r_pr <= i_rf_rdata;
                default: r_pb <= r_pb;
            endcase
        end
        if (((r_state == S_RD) || (r_state == S_WR)) && !w_ok) begin
            r_bad <= 1'b1;
        end
        r_cap_idx <= r_cnt;
        r_cap_ok  <= w_ok;
        if (r_cap_vld) begin
            r_ab[r_cap_idx[4:2]][{r_cap_idx[1:0], 3'b000} +: 8] <= r_cap_ok ? i_bm_rdata : 8'd0;
        end
        // product term t: row t[2], column t[1], inner index t[0]
        r_prod <= r_ab[{1'b0, r_cnt[2], r_cnt[0]}] * r_ab[{1'b1, r_cnt[0], r_cnt[1]}];
        r_pt   <= r_cnt[2:0];
        if (r_pv) begin
            r_res[r_pt[2:1]] <= r_pt[0] ? (r_res[r_pt[2:1]] + r_prod) : r_prod;
        end
        if (w_load) begin
            r_rsp.read_data <= (r_req.func == FN_MEM_RD) ? r_ab[0] : 32'd0;
            r_rsp.status    <= r_illegal ? ST_UNKNOWN : (r_bad ? ST_OOB : ST_OK);
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule
`default_nettype wire

/* src/matmul_2x2_instruction_unit_core.sv */
// top level of the 2x2 matrix multiply instruction unit
// Each request takes one of four actions and gives exactly one response. All
// memory traffic goes byte by byte through a single byte-wide port with
// registered read data, and that port sets the pace. A matrix multiply makes
// 3 register file reads, 32 byte reads, 8 steps through one shared 32-bit
// multiplier and 16 byte writes. One request is worked on at a time; the next
// one is taken while a finished response still waits. The register file reads
// as zero after reset; memory bytes are undefined until written.
`default_nettype none
module matmul_2x2_instruction_unit_core #(
    parameter int MEM_BYTES = 65536
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_req_valid,
    output logic          o_req_ready,
    input  mm2_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  wire           i_rsp_ready,
    output mm2_pkg::t_rsp o_rsp
);
    import mm2_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    t_mem_ctl        rf_ctl;
    logic [4:0]      rf_addr;
    logic [31:0]     rf_wdata;
    logic [31:0]     rf_rdata;
    t_mem_ctl        bm_ctl;
    logic [AW-1:0]   bm_addr;
    logic [7:0]      bm_wdata;
    logic [7:0]      bm_rdata;

    mm2_ctrl #(
        .MEM_BYTES(MEM_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .o_rf_ctl    (rf_ctl),
        .o_rf_addr   (rf_addr),
        .o_rf_wdata  (rf_wdata),
        .i_rf_rdata  (rf_rdata),
        .o_bm_ctl    (bm_ctl),
        .o_bm_addr   (bm_addr),
        .o_bm_wdata  (bm_wdata),
        .i_bm_rdata  (bm_rdata)
    );

    mm2_reg_ram u_rf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rf_ctl),
        .i_addr  (rf_addr),
        .i_wdata (rf_wdata),
        .o_rdata (rf_rdata)
    );

    mm2_byte_ram #(
        .MEM_BYTES(MEM_BYTES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (bm_ctl),
        .i_addr  (bm_addr),
        .i_wdata (bm_wdata),
        .o_rdata (bm_rdata)
    );

endmodule
`default_nettype wire

/* src/mm2_checker.sv */
// port-level checks of the 2x2 matrix multiply instruction unit
`default_nettype none
`include "matmul_2x2_instruction_unit_core_defines.svh"
module mm2_checker (
    input wire           i_clk,
    input wire           i_rst_n,
    input wire           i_req_valid,
    input wire           o_req_ready,
    input mm2_pkg::t_req i_req,
    input wire           o_rsp_valid,
    input wire           i_rsp_ready,
    input mm2_pkg::t_rsp o_rsp
);
    import mm2_pkg::*;

    `MM2_ASSERT_NEXT_RST(a_rst_no_rsp, !i_rst_n, !o_rsp_valid)
    `MM2_ASSERT_NEXT(a_busy_after_req, i_req_valid && o_req_ready, !o_req_ready)
    `MM2_ASSERT_NOW(a_status_legal, o_rsp_valid, o_rsp.status != 2'd3)
    `MM2_ASSERT_NOW(a_bad_reads_zero, o_rsp_valid && (o_rsp.status != ST_OK), o_rsp.read_data == 32'sd0)
    `MM2_ASSERT_NEXT(a_rsp_hold, o_rsp_valid && !i_rsp_ready, o_rsp_valid && $stable(o_rsp))

endmodule

bind matmul_2x2_instruction_unit_core mm2_checker u_mm2_checker (.*);
`default_nettype wire
